[hw/rtl/dsn_pkg.sv]
package dsn_pkg;

    localparam int MAX_LOG2_SIDE = 8;
    localparam int COORD_W       = MAX_LOG2_SIDE;
    localparam int ADDR_W        = 2 * MAX_LOG2_SIDE;
    localparam int IMG_DEPTH     = 2 ** ADDR_W;
    localparam int SIZE_W        = MAX_LOG2_SIDE + 1;
    localparam int LOG_W         = $clog2(MAX_LOG2_SIDE + 1);
    localparam int FORCE_W       = 5;
    localparam int WGT_W         = 4;
    localparam int CFG_W         = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int PIX_W         = 8;
    localparam int SUM_W         = PIX_W + 2;
    localparam int MIX_W         = PIX_W + WGT_W;
    localparam int READS         = 4;
    localparam int CNT_W         = $clog2(READS);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [LOG_W-1:0]   log2_t;
    typedef logic [FORCE_W-1:0] force_t;
    typedef logic [WGT_W-1:0]   wgt_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;
    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [MIX_W-1:0]   mix_t;
    typedef logic [CNT_W-1:0]   rd_cnt_t;

    localparam pix_t      SEED_VALUE        = pix_t'(128);
    localparam wgt_t      FORCE_FULL        = wgt_t'(8);
    localparam force_t    FORCE_MAX         = force_t'(31);
    localparam log2_t     LOG2_MIN          = log2_t'(1);
    localparam log2_t     LOG2_MAX          = log2_t'(MAX_LOG2_SIDE);
    localparam cfg_data_t LOG2_SIDE_RESET   = cfg_data_t'(8);
    localparam cfg_data_t START_FORCE_RESET = cfg_data_t'(0);
    localparam rd_cnt_t   CNT_LAST          = rd_cnt_t'(READS - 1);

    typedef enum logic [1:0] {
        PH_SEED,
        PH_DIAMOND,
        PH_TOP,
        PH_LEFT
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG2_SIDE,
        REG_START_FORCE
    } cfg_reg_t;

    typedef struct packed {
        logic   seed;
        logic   last;
        wgt_t   force_w;
        pix_t   rnd;
        coord_t x;
        coord_t y;
        addr_t  waddr;
    } item_t;

    typedef struct packed {
        logic  valid;
        logic  final_rd;
        addr_t addr;
    } rd_req_t;

    typedef struct packed {
        logic valid;
        logic final_rd;
        pix_t data;
    } rd_rsp_t;

    typedef struct packed {
        logic  pend;
        logic  commit;
        addr_t addr;
        pix_t  data;
    } img_wr_t;

endpackage

[hw/rtl/dsn_in_if.sv]
interface dsn_in_if;
    import dsn_pkg::*;

    logic valid;
    logic ready;
    pix_t random_byte;

    modport source (output valid, output random_byte, input ready);
    modport sink (input valid, input random_byte, output ready);

endinterface

[hw/rtl/dsn_out_if.sv]
interface dsn_out_if;
    import dsn_pkg::*;

    logic valid;
    logic ready;
    pix_t pixel_x;
    pix_t pixel_y;
    pix_t pixel_value;
    logic last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_value,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input pixel_value,
                  input last_pixel, output ready);

endinterface

[hw/rtl/dsn_seq.sv]
module dsn_seq
    import dsn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_data_t log2_side,
    input  cfg_data_t start_force,
    input  logic      b_free,
    dsn_in_if.sink    rand_ch,
    output rd_req_t   rd_req,
    output item_t     item
);

    phase_t  phase_reg, phase_next;
    log2_t   log2_reg, log2_next;
    size_t   size_reg, size_next;
    force_t  force_reg, force_next;
    coord_t  cx_reg, cx_next;
    coord_t  cy_reg, cy_next;

    logic    a_valid_reg, a_valid_next;
    rd_cnt_t a_cnt_reg, a_cnt_next;
    addr_t   a_addr_reg [READS];
    addr_t   a_addr_next [READS];
    item_t   a_item_reg, a_item_next;

    logic    accept;
    size_t   side;
    coord_t  mask;
    coord_t  c_w;
    coord_t  h_w;
    size_t   half_size;
    size_t   nx;
    size_t   ny;
    logic    wrap_x;
    logic    wrap_y;
    logic    pass_done;
    coord_t  cx_adv;
    coord_t  cy_adv;
    log2_t   new_log2;
    coord_t  rx [READS];
    coord_t  ry [READS];
    coord_t  wx;
    coord_t  wy;
    coord_t  wxm;
    coord_t  wym;
    logic    is_seed;
    logic    is_last;
    wgt_t    wgt;

    function automatic log2_t clamp_log2(input cfg_data_t v);
        log2_t r;
        if (v == '0)
            r = LOG2_MIN;
        else if (v > cfg_data_t'(MAX_LOG2_SIDE))
            r = LOG2_MAX;
        else
            r = log2_t'(v);
        return r;
    endfunction

    function automatic addr_t pix_addr(input coord_t x, input coord_t y, input log2_t l);
        return (addr_t'(y) << l) | addr_t'(x);
    endfunction

    // read issue for the item held in the address stage
    always_comb
    begin
        rand_ch.ready   = !a_valid_reg || ((a_cnt_reg == CNT_LAST) && b_free);
        accept          = rand_ch.valid && rand_ch.ready;
        rd_req.valid    = a_valid_reg && ((a_cnt_reg != CNT_LAST) || b_free);
        rd_req.final_rd = (a_cnt_reg == CNT_LAST);
        rd_req.addr     = a_addr_reg[a_cnt_reg];
        item            = a_item_reg;
    end

    // generation order and neighbour addresses
    always_comb
    begin
        side      = size_t'(1) << log2_reg;
        mask      = coord_t'(side - size_t'(1));
        c_w       = coord_t'(size_reg);
        h_w       = coord_t'(size_reg >> 1);
        half_size = size_reg >> 1;
        nx        = size_t'(cx_reg) + size_reg;
        ny        = size_t'(cy_reg) + size_reg;
        wrap_x    = (nx >= side);
        wrap_y    = (ny >= side);
        pass_done = wrap_x && wrap_y;
        cx_adv    = wrap_x ? '0 : coord_t'(nx);
        cy_adv    = wrap_x ? (wrap_y ? '0 : coord_t'(ny)) : cy_reg;
        new_log2  = clamp_log2(log2_side);
        wgt       = (force_reg >= force_t'(FORCE_FULL)) ? FORCE_FULL : wgt_t'(force_reg);

        phase_next = phase_reg;
        log2_next  = log2_reg;
        size_next  = size_reg;
        force_next = force_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        for (int k = 0; k < READS; k++)
        begin
            rx[k] = cx_reg;
            ry[k] = cy_reg;
        end
        wx      = cx_reg;
        wy      = cy_reg;
        is_seed = 1'b0;
        is_last = 1'b0;

        case (phase_reg)
            PH_SEED:
            begin
                is_seed = 1'b1;
                for (int k = 0; k < READS; k++)
                begin
                    rx[k] = '0;
                    ry[k] = '0;
                end
                wx         = '0;
                wy         = '0;
                phase_next = PH_DIAMOND;
                log2_next  = new_log2;
                size_next  = size_t'(1) << new_log2;
                force_next = force_t'(start_force);
                cx_next    = '0;
                cy_next    = '0;
            end
            PH_DIAMOND:
            begin
                rx[1]   = cx_reg + c_w;
                rx[3]   = cx_reg + c_w;
                ry[2]   = cy_reg + c_w;
                ry[3]   = cy_reg + c_w;
                wx      = cx_reg + h_w;
                wy      = cy_reg + h_w;
                cx_next = cx_adv;
                cy_next = cy_adv;
                if (pass_done)
                    phase_next = PH_TOP;
            end
            PH_TOP:
            begin
                rx[1]      = cx_reg + h_w;
                ry[1]      = cy_reg + h_w;
                rx[2]      = cx_reg + c_w;
                rx[3]      = cx_reg + h_w;
                ry[3]      = cy_reg - h_w;
                wx         = cx_reg + h_w;
                phase_next = PH_LEFT;
            end
            PH_LEFT:
            begin
                rx[1]   = cx_reg + h_w;
                ry[1]   = cy_reg + h_w;
                ry[2]   = cy_reg + c_w;
                rx[3]   = cx_reg - h_w;
                ry[3]   = cy_reg + h_w;
                wy      = cy_reg + h_w;
                cx_next = cx_adv;
                cy_next = cy_adv;
                if (pass_done)
                begin
                    size_next = half_size;
                    if (force_reg != FORCE_MAX)
                        force_next = force_reg + force_t'(1);
                    if (half_size < size_t'(2))
                    begin
                        is_last    = 1'b1;
                        phase_next = PH_SEED;
                    end
                    else
                        phase_next = PH_DIAMOND;
                end
                else
                    phase_next = PH_TOP;
            end
            default:
            begin
                phase_next = PH_SEED;
            end
        endcase

        if (!accept)
        begin
            phase_next = phase_reg;
            log2_next  = log2_reg;
            size_next  = size_reg;
            force_next = force_reg;
            cx_next    = cx_reg;
            cy_next    = cy_reg;
        end

        wxm = wx & mask;
        wym = wy & mask;

        a_item_next = a_item_reg;
        for (int k = 0; k < READS; k++)
            a_addr_next[k] = a_addr_reg[k];
        if (accept)
        begin
            a_item_next = '{seed: is_seed, last: is_last, force_w: wgt,
                            rnd: rand_ch.random_byte, x: wxm, y: wym,
                            waddr: pix_addr(wxm, wym, log2_reg)};
            for (int k = 0; k < READS; k++)
                a_addr_next[k] = pix_addr(rx[k] & mask, ry[k] & mask, log2_reg);
        end

        if (accept)
            a_valid_next = 1'b1;
        else if (rd_req.valid && rd_req.final_rd)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;

        if (accept)
            a_cnt_next = '0;
        else if (rd_req.valid)
            a_cnt_next = a_cnt_reg + rd_cnt_t'(1);
        else
            a_cnt_next = a_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEED;
            log2_reg    <= LOG2_MAX;
            size_reg    <= size_t'(1) << LOG2_MAX;
            force_reg   <= force_t'(START_FORCE_RESET);
            cx_reg      <= '0;
            cy_reg      <= '0;
            a_valid_reg <= 1'b0;
            a_cnt_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            log2_reg    <= log2_next;
            size_reg    <= size_next;
            force_reg   <= force_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            a_valid_reg <= a_valid_next;
            a_cnt_reg   <= a_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= a_item_next;
        for (int k = 0; k < READS; k++)
            a_addr_reg[k] <= a_addr_next[k];
    end

endmodule

[hw/rtl/dsn_image_mem.sv]
module dsn_image_mem
    import dsn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  rd_req_t rd_req,
    input  img_wr_t img_wr,
    output rd_rsp_t rd_rsp
);

    pix_t  ram [IMG_DEPTH];
    pix_t  rdata_reg;
    logic  ret_valid_reg;
    logic  ret_final_reg;
    addr_t ret_addr_reg;
    logic  lw_valid_reg;
    addr_t lw_addr_reg;
    pix_t  lw_data_reg;

    always_ff @(posedge clk)
    begin
        if (img_wr.commit)
            ram[img_wr.addr] <= img_wr.data;
        if (rd_req.valid)
            rdata_reg <= ram[rd_req.addr];
    end

    always_ff @(posedge clk)
    begin
        ret_addr_reg <= rd_req.addr;
        if (img_wr.commit)
        begin
            lw_addr_reg <= img_wr.addr;
            lw_data_reg <= img_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ret_valid_reg <= 1'b0;
            ret_final_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            ret_valid_reg <= rd_req.valid;
            ret_final_reg <= rd_req.valid && rd_req.final_rd;
            if (img_wr.commit)
                lw_valid_reg <= 1'b1;
        end
    end

    // pending pixel first, then the write that raced the read
    always_comb
    begin
        rd_rsp.valid    = ret_valid_reg;
        rd_rsp.final_rd = ret_final_reg;
        if (img_wr.pend && (img_wr.addr == ret_addr_reg))
            rd_rsp.data = img_wr.data;
        else if (lw_valid_reg && (lw_addr_reg == ret_addr_reg))
            rd_rsp.data = lw_data_reg;
        else
            rd_rsp.data = rdata_reg;
    end

endmodule

[hw/rtl/dsn_blend.sv]
module dsn_blend
    import dsn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rd_req_t   rd_req,
    input  item_t     item,
    input  rd_rsp_t   rd_rsp,
    output img_wr_t   img_wr,
    output logic      b_free,
    dsn_out_if.source pixel_ch
);

    item_t pend_item_reg;
    sum_t  acc_reg, acc_next;
    logic  b_valid_reg, b_valid_next;
    sum_t  b_sum_reg;
    item_t b_item_reg;
    logic  o_valid_reg, o_valid_next;
    pix_t  o_x_reg;
    pix_t  o_y_reg;
    pix_t  o_value_reg;
    logic  o_last_reg;

    sum_t  rsp_sum;
    pix_t  avg;
    mix_t  mix;
    pix_t  value;
    logic  b_fire;
    logic  rsp_final;

    always_comb
    begin
        rsp_sum   = acc_reg + sum_t'(rd_rsp.data);
        rsp_final = rd_rsp.valid && rd_rsp.final_rd;
        avg       = b_sum_reg[SUM_W-1:2];
        mix       = mix_t'(b_item_reg.rnd) * mix_t'(FORCE_FULL - b_item_reg.force_w)
                  + mix_t'(avg) * mix_t'(b_item_reg.force_w);
        if (b_item_reg.seed)
            value = SEED_VALUE;
        else if (b_item_reg.force_w >= FORCE_FULL)
            value = avg;
        else
            value = mix[PIX_W+2:3];

        b_fire = b_valid_reg && (!o_valid_reg || pixel_ch.ready);
        b_free = !b_valid_reg || b_fire;

        img_wr.pend   = b_valid_reg;
        img_wr.commit = b_fire;
        img_wr.addr   = b_item_reg.waddr;
        img_wr.data   = value;

        if (rd_rsp.valid)
            acc_next = rd_rsp.final_rd ? '0 : rsp_sum;
        else
            acc_next = acc_reg;

        if (rsp_final)
            b_valid_next = 1'b1;
        else if (b_fire)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;

        if (b_fire)
            o_valid_next = 1'b1;
        else if (pixel_ch.ready)
            o_valid_next = 1'b0;
        else
            o_valid_next = o_valid_reg;

        pixel_ch.valid       = o_valid_reg;
        pixel_ch.pixel_x     = o_x_reg;
        pixel_ch.pixel_y     = o_y_reg;
        pixel_ch.pixel_value = o_value_reg;
        pixel_ch.last_pixel  = o_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.valid && rd_req.final_rd)
            pend_item_reg <= item;
        if (rsp_final)
        begin
            b_sum_reg  <= rsp_sum;
            b_item_reg <= pend_item_reg;
        end
        if (b_fire)
        begin
            o_x_reg     <= pix_t'(b_item_reg.x);
            o_y_reg     <= pix_t'(b_item_reg.y);
            o_value_reg <= value;
            o_last_reg  <= b_item_reg.last;
        end
    end

endmodule

[hw/rtl/diamond_square_noise_generator.sv]
// Diamond-square grey noise generator with toroidal wrap. Every item on rand_ch carries one
// random byte and yields exactly one pixel on pixel_ch (column, row, grey value), in generation
// order: the seed corner (always 128), then per level a diamond pass over the cell centres and a
// square pass over the top and left edge midpoints; last_pixel marks the end of an image and the
// next item starts a new one. Register 0 (log2_side, saturated to 1..8) and register 1
// (start_force, any value of 8 or more means no randomness) are sampled on the seed pixel only.
// Each pixel needs four earlier pixels, read one per cycle (the last once the blend stage is
// free) through the single read port of the 64 KiB image memory, which has one write port
// beside it; a new item is taken as the last read of the one before issues. The image memory
// needs no clearing after reset, as every entry is written before it is read.
module diamond_square_noise_generator
    import dsn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  cfg_data_t            cfg_data,
    dsn_in_if.sink               rand_ch,
    dsn_out_if.source            pixel_ch
);

    cfg_data_t log2_side_reg;
    cfg_data_t start_force_reg;

    rd_req_t   rd_req;
    rd_rsp_t   rd_rsp;
    img_wr_t   img_wr;
    item_t     item;
    logic      b_free;
    logic      item_accepted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_side_reg   <= LOG2_SIDE_RESET;
            start_force_reg <= START_FORCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOG2_SIDE:   log2_side_reg   <= cfg_data;
                REG_START_FORCE: start_force_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    dsn_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .log2_side   (log2_side_reg),
        .start_force (start_force_reg),
        .b_free      (b_free),
        .rand_ch     (rand_ch),
        .rd_req      (rd_req),
        .item        (item)
    );

    dsn_image_mem u_image_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_req (rd_req),
        .img_wr (img_wr),
        .rd_rsp (rd_rsp)
    );

    dsn_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_req   (rd_req),
        .item     (item),
        .rd_rsp   (rd_rsp),
        .img_wr   (img_wr),
        .b_free   (b_free),
        .pixel_ch (pixel_ch)
    );

    assign item_accepted = rand_ch.valid && rand_ch.ready;

    // an item holds the read port for all of its neighbour reads
    a_item_occupies: assert property (@(posedge clk) disable iff (!rst_n)
        item_accepted |=> !rand_ch.ready ##1 !rand_ch.ready ##1 !rand_ch.ready)
        else $error("item taken while the previous one still reads");

    a_read_return: assert property (@(posedge clk) disable iff (!rst_n)
        rd_req.valid && rd_req.final_rd |=> rd_rsp.valid && rd_rsp.final_rd)
        else $error("last neighbour read did not return");

    a_sum_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        rd_rsp.valid && rd_rsp.final_rd |=> img_wr.pend)
        else $error("finished sum not held for blending");

    a_write_shown: assert property (@(posedge clk) disable iff (!rst_n)
        img_wr.commit |=> pixel_ch.valid)
        else $error("written pixel not presented");

endmodule

[tb/sv/dsn_pixel_check.sv]
module dsn_pixel_check
    import dsn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  cfg_data_t            cfg_data,
    dsn_in_if                    rand_mon,
    dsn_out_if                   pixel_mon,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        pix_t x;
        pix_t y;
        pix_t value;
        logic last;
    } pixel_exp_t;

    pix_t       img_store [IMG_DEPTH];
    cfg_data_t  reg_log2;
    cfg_data_t  reg_force;
    int         side;
    int         cell_size;
    int         lvl_force;
    int         cx;
    int         cy;
    phase_t     phase;
    pixel_exp_t pixel_q[$];
    pixel_exp_t want;
    int         pixel_no;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        pixel_no    = 0;
        foreach (img_store[i])
            img_store[i] = '0;
    end

    function automatic int side_of(cfg_data_t v);
        if (v < LOG2_MIN)
            return 1 << LOG2_MIN;
        if (v > LOG2_MAX)
            return 1 << LOG2_MAX;
        return 1 << v;
    endfunction

    function automatic int store_index(int x, int y);
        int m;
        m = side - 1;
        return (y & m) * side + (x & m);
    endfunction

    function automatic int pixel_at(int x, int y);
        return int'(img_store[store_index(x, y)]);
    endfunction

    function automatic void store_pixel(int x, int y, int v);
        img_store[store_index(x, y)] = pix_t'(v);
    endfunction

    function automatic int mix(int sum, pix_t rnd);
        int avg;
        int full;
        avg  = (sum >> 2) & 255;
        full = int'(FORCE_FULL);
        if (lvl_force >= full)
            return avg;
        return (int'(rnd) * (full - lvl_force) + avg * lvl_force) >> 3;
    endfunction

    // returns 1 once the pass has covered every cell
    function automatic bit step_cell();
        cx += cell_size;
        if (cx >= side)
        begin
            cx = 0;
            cy += cell_size;
            if (cy >= side)
            begin
                cy = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic pixel_exp_t next_pixel(pix_t rnd);
        int         c;
        int         h;
        int         x;
        int         y;
        int         v;
        int         sum;
        logic       last;
        pixel_exp_t e;
        c    = cell_size;
        h    = c >> 1;
        x    = 0;
        y    = 0;
        v    = 0;
        last = 1'b0;
        case (phase)
            PH_SEED:
            begin
                side      = side_of(reg_log2);
                cell_size = side;
                lvl_force = int'(reg_force);
                cx        = 0;
                cy        = 0;
                v         = int'(SEED_VALUE);
                store_pixel(0, 0, v);
                phase     = PH_DIAMOND;
            end
            PH_DIAMOND:
            begin
                sum = pixel_at(cx, cy) + pixel_at(cx + c, cy)
                    + pixel_at(cx, cy + c) + pixel_at(cx + c, cy + c);
                x = cx + h;
                y = cy + h;
                v = mix(sum, rnd);
                store_pixel(x, y, v);
                if (step_cell())
                    phase = PH_TOP;
            end
            PH_TOP:
            begin
                sum = pixel_at(cx, cy) + pixel_at(cx + h, cy + h)
                    + pixel_at(cx + c, cy) + pixel_at(cx + h, cy - h);
                x = cx + h;
                y = cy;
                v = mix(sum, rnd);
                store_pixel(x, y, v);
                phase = PH_LEFT;
            end
            default:
            begin
                sum = pixel_at(cx, cy) + pixel_at(cx + h, cy + h)
                    + pixel_at(cx, cy + c) + pixel_at(cx - h, cy + h);
                x = cx;
                y = cy + h;
                v = mix(sum, rnd);
                store_pixel(x, y, v);
                if (step_cell())
                begin
                    cell_size = c >> 1;
                    if (lvl_force < int'(FORCE_MAX))
                        lvl_force++;
                    if (cell_size < 2)
                    begin
                        last  = 1'b1;
                        phase = PH_SEED;
                    end
                    else
                        phase = PH_DIAMOND;
                end
                else
                    phase = PH_TOP;
            end
        endcase
        e.x     = pix_t'(x & (side - 1));
        e.y     = pix_t'(y & (side - 1));
        e.value = pix_t'(v);
        e.last  = last;
        return e;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int exp_v);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch on %s at pixel %0d: got %0d, expected %0d",
                     field, pixel_no, got, exp_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_log2  = LOG2_SIDE_RESET;
            reg_force = START_FORCE_RESET;
            side      = side_of(reg_log2);
            cell_size = side;
            lvl_force = int'(reg_force);
            cx        = 0;
            cy        = 0;
            phase     = PH_SEED;
            pixel_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_LOG2_SIDE:   reg_log2  = cfg_data;
                    REG_START_FORCE: reg_force = cfg_data;
                    default: ;
                endcase
            end
            if (rand_mon.valid && rand_mon.ready)
                pixel_q.push_back(next_pixel(rand_mon.random_byte));
            if (pixel_mon.valid && pixel_mon.ready)
            begin
                if (pixel_q.size() == 0)
                    report_mismatch("pixel with nothing expected", int'(pixel_mon.pixel_x), -1);
                else
                begin
                    want = pixel_q.pop_front();
                    if (pixel_mon.pixel_x !== want.x)
                        report_mismatch("pixel_x", int'(pixel_mon.pixel_x), int'(want.x));
                    if (pixel_mon.pixel_y !== want.y)
                        report_mismatch("pixel_y", int'(pixel_mon.pixel_y), int'(want.y));
                    if (pixel_mon.pixel_value !== want.value)
                        report_mismatch("pixel_value", int'(pixel_mon.pixel_value),
                                        int'(want.value));
                    if (pixel_mon.last_pixel !== want.last)
                        report_mismatch("last_pixel", int'(pixel_mon.last_pixel),
                                        int'(want.last));
                end
                pixel_no++;
            end
            outstanding = pixel_q.size();
        end
    end

endmodule

[tb/sv/tb_diamond_square_noise_generator.sv]
module tb_diamond_square_noise_generator;
    import dsn_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 12;
    localparam int HOLD_OFF    = 300;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    cfg_data_t            cfg_data;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_cycles;
    int                   quiet_cycles;
    int                   mismatches;
    int                   outstanding;

    dsn_in_if  rand_ch ();
    dsn_out_if pixel_ch ();

    diamond_square_noise_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rand_ch   (rand_ch),
        .pixel_ch  (pixel_ch)
    );

    dsn_pixel_check pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rand_mon    (rand_ch),
        .pixel_mon   (pixel_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // receiver: random stalls, or a long hold-off while the sender keeps offering
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            pixel_ch.ready <= 1'b0;
            hold_cycles    <= hold_cycles - 1;
        end
        else
            pixel_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rand_ch.valid && rand_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 80; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            IDLE_BOTH:     begin send_idle_pct = 23; recv_stall_pct = 23; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic set_regs(input cfg_data_t log2_val, input cfg_data_t force_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOG2_SIDE;
        cfg_data  <= log2_val;
        @(posedge clk);
        cfg_index <= REG_START_FORCE;
        cfg_data  <= force_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_byte(input pix_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rand_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rand_ch.valid       <= 1'b1;
        rand_ch.random_byte <= b;
        @(posedge clk);
        while (!rand_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_byte(pix_t'($urandom_range(0, 255)));
    endtask

    // every pixel back, then a settling pause with the sender idle
    task automatic wait_idle();
        rand_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int phase_no;
        int random_items;
        int log2_val;
        int force_val;
        int images;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        rand_ch.valid       = 1'b0;
        rand_ch.random_byte = '0;
        pixel_ch.ready      = 1'b0;
        hold_cycles         = 0;
        quiet_cycles        = 0;
        set_idling(IDLE_NONE);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest image, full randomness, byte extremes
        set_regs(cfg_data_t'(1), cfg_data_t'(0));
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();

        // side below range, force of eight; registers rewritten mid-image
        set_regs(cfg_data_t'(0), cfg_data_t'(8));
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_idle();
        set_regs(cfg_data_t'(2), cfg_data_t'(15));
        send_byte(8'hFF);
        send_byte(8'h00);
        for (int i = 0; i < 16; i++)
            send_byte((i % 2 == 0) ? 8'hFF : 8'h00);
        wait_idle();

        phase_no     = 0;
        random_items = 0;
        while (random_items < 350)
        begin
            log2_val  = $urandom_range(1, 3);
            images    = (log2_val <= 2) ? $urandom_range(1, 4) : 1;
            force_val = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 15)
                                                    : $urandom_range(0, 7);
            set_idling(idle_mode_t'(phase_no % 4));
            set_regs(cfg_data_t'(log2_val), cfg_data_t'(force_val));
            send_random(images << (2 * log2_val));
            random_items += images << (2 * log2_val);
            phase_no++;
            wait_idle();
        end

        // receiver holds off so the block backs up onto its input
        set_idling(IDLE_NONE);
        set_regs(cfg_data_t'(3), cfg_data_t'(2));
        hold_cycles <= HOLD_OFF;
        send_random(64);
        wait_idle();

        // side above range saturates, left unfinished
        set_idling(IDLE_BOTH);
        set_regs(cfg_data_t'(15), cfg_data_t'(0));
        send_random(120);
        wait_idle();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
